### rtl/core/rsd_pkg.sv
// Shared types and constants for the run/skip/dump frame decoder.
package rsd_pkg;

	localparam int unsigned ADDRESS_WIDTH_DEFAULT = 16;
	localparam logic [15:0] FRAME_PIXELS_RESET    = 16'd64000;

	localparam int unsigned CountBits = 14;

	// Opcode and long-code boundaries
	localparam logic [7:0]  OPC_RUN       = 8'h00;
	localparam logic [7:0]  OPC_LONG      = 8'h80;
	localparam logic [15:0] LONG_STOP     = 16'h0000;
	localparam logic [15:0] LONG_RUN_BASE = 16'hC000;
	localparam logic [15:0] LONG_DMP_BASE = 16'h8000;

	// command_kind codes
	localparam logic [1:0] KIND_PIXEL    = 2'd0;
	localparam logic [1:0] KIND_FILL     = 2'd1;
	localparam logic [1:0] KIND_STOP     = 2'd2;
	localparam logic [1:0] KIND_OVERFLOW = 2'd3;

	typedef enum logic [2:0] {
		PH_OPCODE,
		PH_RUN_LEN,
		PH_RUN_VAL,
		PH_DUMP,
		PH_LONG_LO,
		PH_LONG_HI
	} phase_t;

	typedef struct packed {
		logic [1:0]           command_kind;
		logic [15:0]          pixel_address;
		logic [CountBits-1:0] run_length;
		logic [7:0]           pixel_value;
	} cmd_t;

endpackage

### rtl/core/rsd_code_if.sv
// Valid/ready channel carrying compressed code bytes into the decoder.
interface rsd_code_if;
	logic       valid;
	logic       ready;
	logic [7:0] code_byte;
	logic       record_start;

	modport source (output valid, output code_byte, output record_start, input ready);
	modport sink   (input valid, input code_byte, input record_start, output ready);
endinterface

### rtl/core/rsd_cmd_if.sv
// Valid/ready channel carrying frame-buffer commands out of the decoder.
interface rsd_cmd_if;
	logic                           valid;
	logic                           ready;
	logic [1:0]                     command_kind;
	logic [15:0]                    pixel_address;
	logic [rsd_pkg::CountBits-1:0]  run_length;
	logic [7:0]                     pixel_value;

	modport source (output valid, output command_kind, output pixel_address,
		output run_length, output pixel_value, input ready);
	modport sink   (input valid, input command_kind, input pixel_address,
		input run_length, input pixel_value, output ready);
endinterface

### rtl/core/run_skip_dump_decoder.sv
// Run/skip/dump animation body decoder: one code byte in, at most one command out.
// Each command is registered in the result register, or in the skid slot if the output stalls.
// Throughput: one code byte per cycle while the skid slot is empty; the parser state updates in the accept cycle
//   and a two-entry output buffer (result register plus skid) decouples the sides.
// Reset (arst_n low, asynchronous): parser expects an opcode, address, count, stop
//   and overflow flags clear, output buffer empty, frame_pixels returns to 64000.
module run_skip_dump_decoder #(
	parameter int unsigned ADDRESS_WIDTH = rsd_pkg::ADDRESS_WIDTH_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	rsd_code_if.sink    code_ch,
	rsd_cmd_if.source   cmd_ch,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata
);

	// write_address has one bit beyond ADDRESS_WIDTH and saturates at all ones
	localparam int unsigned AddrBits = ADDRESS_WIDTH + 1;
	// wide enough for address + 15-bit skip and for compare against 16-bit frame size
	localparam int unsigned SumBits  = ((AddrBits > 16) ? AddrBits : 16) + 1;
	localparam int unsigned CntBits  = rsd_pkg::CountBits;

	// ---------------- decoder state ----------------
	rsd_pkg::phase_t       phase_q;
	logic [AddrBits-1:0]   addr_q;
	logic [CntBits-1:0]    rem_q;
	logic [7:0]            low_q;
	logic                  stopped_q;
	logic                  ovf_q;
	logic [15:0]           frame_q;

	// values after an optional record_start clear
	rsd_pkg::phase_t       phase_e;
	logic [AddrBits-1:0]   addr_e;
	logic [CntBits-1:0]    rem_e;
	logic [7:0]            low_e;
	logic                  stopped_e;
	logic                  ovf_e;

	// next-state values
	rsd_pkg::phase_t       phase_n;
	logic [AddrBits-1:0]   addr_n;
	logic [CntBits-1:0]    rem_n;
	logic [7:0]            low_n;
	logic                  stopped_n;
	logic                  ovf_n;

	// a write or fill request out of the parser
	logic                  wr_req;
	logic [1:0]            wr_kind;
	logic [CntBits-1:0]    wr_len;
	logic [7:0]            wr_val;
	logic [14:0]           adv;

	logic                  res_valid;
	rsd_pkg::cmd_t         res;

	logic [15:0]           long_code;
	logic [CntBits-1:0]    rem_dec;
	logic [SumBits-1:0]    adv_sum;
	logic [SumBits-1:0]    end_sum;
	logic [SumBits-1:0]    addr_max;

	// ---------------- output buffer ----------------
	rsd_pkg::cmd_t         out_q;
	logic                  out_valid_q;
	rsd_pkg::cmd_t         skid_q;
	logic                  skid_valid_q;
	logic                  in_fire;
	logic                  out_fire;

	// Input is held off only while the skid slot is occupied.
	assign code_ch.ready = !skid_valid_q;
	assign in_fire       = code_ch.valid && code_ch.ready;
	assign out_fire      = cmd_ch.valid && cmd_ch.ready;

	assign addr_max  = SumBits'({AddrBits{1'b1}});
	assign long_code = {code_ch.code_byte, low_e};
	assign rem_dec   = (rem_e != '0) ? rem_e - CntBits'(1) : '0;

	always_comb begin
		// record_start clears everything before the byte is parsed
		if (code_ch.record_start) begin
			phase_e   = rsd_pkg::PH_OPCODE;
			addr_e    = '0;
			rem_e     = '0;
			low_e     = '0;
			stopped_e = 1'b0;
			ovf_e     = 1'b0;
		end else begin
			phase_e   = phase_q;
			addr_e    = addr_q;
			rem_e     = rem_q;
			low_e     = low_q;
			stopped_e = stopped_q;
			ovf_e     = ovf_q;
		end
	end

	always_comb begin
		phase_n   = phase_e;
		rem_n     = rem_e;
		low_n     = low_e;
		stopped_n = stopped_e;
		ovf_n     = ovf_e;
		wr_req    = 1'b0;
		wr_kind   = rsd_pkg::KIND_PIXEL;
		wr_len    = CntBits'(1);
		wr_val    = code_ch.code_byte;
		adv       = '0;
		res_valid = 1'b0;
		res       = '{command_kind: rsd_pkg::KIND_STOP,
			pixel_address: 16'(addr_e), run_length: '0, pixel_value: '0};

		// once stopped, bytes are swallowed until the next record start
		if (!stopped_e) begin
			case (phase_e)
				rsd_pkg::PH_OPCODE: begin
					if (code_ch.code_byte == rsd_pkg::OPC_RUN) begin
						phase_n = rsd_pkg::PH_RUN_LEN;
					end else if (code_ch.code_byte > rsd_pkg::OPC_LONG) begin
						// short skip: low seven bits
						adv = 15'(code_ch.code_byte[6:0]);
					end else if (code_ch.code_byte < rsd_pkg::OPC_LONG) begin
						rem_n   = CntBits'(code_ch.code_byte);
						phase_n = rsd_pkg::PH_DUMP;
					end else begin
						phase_n = rsd_pkg::PH_LONG_LO;
					end
				end
				rsd_pkg::PH_RUN_LEN: begin
					rem_n   = CntBits'(code_ch.code_byte);
					phase_n = rsd_pkg::PH_RUN_VAL;
				end
				rsd_pkg::PH_RUN_VAL: begin
					phase_n = rsd_pkg::PH_OPCODE;
					// zero-length run emits nothing
					if (rem_e != '0) begin
						rem_n   = '0;
						wr_req  = 1'b1;
						wr_kind = rsd_pkg::KIND_FILL;
						wr_len  = rem_e;
					end
				end
				rsd_pkg::PH_DUMP: begin
					rem_n  = rem_dec;
					if (rem_dec == '0) begin
						phase_n = rsd_pkg::PH_OPCODE;
					end
					wr_req = 1'b1;
				end
				rsd_pkg::PH_LONG_LO: begin
					low_n   = code_ch.code_byte;
					phase_n = rsd_pkg::PH_LONG_HI;
				end
				rsd_pkg::PH_LONG_HI: begin
					phase_n = rsd_pkg::PH_OPCODE;
					if (long_code == rsd_pkg::LONG_STOP) begin
						// stop is reported even after an overflow
						stopped_n = 1'b1;
						res_valid = 1'b1;
					end else if (long_code >= rsd_pkg::LONG_RUN_BASE) begin
						rem_n   = long_code[CntBits-1:0];
						phase_n = rsd_pkg::PH_RUN_VAL;
					end else if (long_code < rsd_pkg::LONG_DMP_BASE) begin
						adv = long_code[14:0];
					end else begin
						rem_n = long_code[CntBits-1:0];
						if (long_code[CntBits-1:0] != '0) begin
							phase_n = rsd_pkg::PH_DUMP;
						end
					end
				end
				default: begin
					phase_n = rsd_pkg::PH_OPCODE;
				end
			endcase
		end

		// write/fill: address always advances, result depends on overflow
		if (wr_req) begin
			adv = 15'(wr_len);
			if (!ovf_e) begin
				res_valid = 1'b1;
				res.run_length  = wr_len;
				res.pixel_value = wr_val;
				if (end_sum > SumBits'(frame_q)) begin
					ovf_n            = 1'b1;
					res.command_kind = rsd_pkg::KIND_OVERFLOW;
				end else begin
					res.command_kind = wr_kind;
				end
			end
		end
	end

	assign end_sum = SumBits'(addr_e) + SumBits'(wr_len);
	assign adv_sum = SumBits'(addr_e) + SumBits'(adv);
	// saturating address advance
	assign addr_n  = (adv_sum > addr_max) ? addr_max[AddrBits-1:0] : adv_sum[AddrBits-1:0];

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q <= rsd_pkg::FRAME_PIXELS_RESET;
		end else if (cfg_we) begin
			frame_q <= cfg_wdata;
		end
	end

	// parser state advances on every accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= rsd_pkg::PH_OPCODE;
			addr_q    <= '0;
			rem_q     <= '0;
			low_q     <= '0;
			stopped_q <= 1'b0;
			ovf_q     <= 1'b0;
		end else if (in_fire) begin
			phase_q   <= phase_n;
			addr_q    <= addr_n;
			rem_q     <= rem_n;
			low_q     <= low_n;
			stopped_q <= stopped_n;
			ovf_q     <= ovf_n;
		end
	end

	// result register plus skid slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			// input is stalled; drain the skid into the result register
			if (out_fire) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end
		end else if (in_fire && res_valid) begin
			if (!out_valid_q || out_fire) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (out_fire) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_fire) begin
				out_q <= skid_q;
			end
		end else if (in_fire && res_valid) begin
			if (!out_valid_q || out_fire) begin
				out_q <= res;
			end else begin
				skid_q <= res;
			end
		end
	end

	assign cmd_ch.valid         = out_valid_q;
	assign cmd_ch.command_kind  = out_q.command_kind;
	assign cmd_ch.pixel_address = out_q.pixel_address;
	assign cmd_ch.run_length    = out_q.run_length;
	assign cmd_ch.pixel_value   = out_q.pixel_value;

endmodule

### tb/run_skip_dump_decoder_tb.sv
// Self-checking testbench for the run/skip/dump frame decoder.
`timescale 1ns / 100ps

module run_skip_dump_decoder_tb;

	// 17-bit write address, saturating at all ones
	localparam int unsigned ADDR_BITS   = rsd_pkg::ADDRESS_WIDTH_DEFAULT + 1;
	localparam int unsigned ADDR_MAX    = (1 << ADDR_BITS) - 1;
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned DRAIN_CYCLES = 6;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [15:0] cfg_wdata;

	rsd_code_if code_ch ();
	rsd_cmd_if  cmd_ch ();

	run_skip_dump_decoder u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.code_ch   (code_ch),
		.cmd_ch    (cmd_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #2 clk = ~clk;

	// ------------------------------------------------------------------
	// Decoder shadow state, advanced once per accepted code byte
	// ------------------------------------------------------------------
	rsd_pkg::phase_t        ph;
	logic [ADDR_BITS-1:0]   wr_addr;
	logic [14:0]            remaining;
	logic [7:0]             long_lo;
	bit                     stopped;
	bit                     overflowed;
	logic [15:0]            frame_px;

	rsd_pkg::cmd_t expected_cmds[$];

	int  mismatch_count = 0;
	int  items_sent     = 0;
	int  cycle_count    = 0;
	int  src_idle_pct   = 0;
	int  snk_stall_pct  = 0;
	int  hold_off_left  = 0;
	bit  start_pending  = 1'b0;

	task automatic advance_addr(input int unsigned n);
		int unsigned sum;
		sum = int'(wr_addr) + n;
		if (sum > ADDR_MAX)
			sum = ADDR_MAX;
		wr_addr = ADDR_BITS'(sum);
	endtask

	// Pixel write or fill: the address always moves on, but once the frame
	// has overflowed nothing more is reported until the next record start.
	task automatic issue_write(input logic [1:0] kind, input int unsigned len,
			input logic [7:0] val);
		int unsigned   addr;
		rsd_pkg::cmd_t c;
		addr = int'(wr_addr);
		advance_addr(len);
		if (overflowed)
			return;
		c.pixel_address = addr[15:0];
		c.run_length    = rsd_pkg::CountBits'(len);
		c.pixel_value   = val;
		if (addr + len > int'(frame_px)) begin
			overflowed     = 1'b1;
			c.command_kind = rsd_pkg::KIND_OVERFLOW;
		end else begin
			c.command_kind = kind;
		end
		expected_cmds.push_back(c);
	endtask

	task automatic decode_byte(input logic [7:0] b, input bit start);
		logic [15:0]   code;
		int unsigned   len;
		rsd_pkg::cmd_t c;
		if (start) begin
			ph         = rsd_pkg::PH_OPCODE;
			wr_addr    = '0;
			remaining  = '0;
			long_lo    = '0;
			stopped    = 1'b0;
			overflowed = 1'b0;
		end
		// everything after the stop code is ignored
		if (stopped)
			return;
		case (ph)
			rsd_pkg::PH_OPCODE: begin
				if (b == rsd_pkg::OPC_RUN) begin
					ph = rsd_pkg::PH_RUN_LEN;
				end else if (b > rsd_pkg::OPC_LONG) begin
					advance_addr(32'(b - rsd_pkg::OPC_LONG));
				end else if (b < rsd_pkg::OPC_LONG) begin
					remaining = 15'(b);
					ph        = rsd_pkg::PH_DUMP;
				end else begin
					ph = rsd_pkg::PH_LONG_LO;
				end
			end
			rsd_pkg::PH_RUN_LEN: begin
				remaining = 15'(b);
				ph        = rsd_pkg::PH_RUN_VAL;
			end
			rsd_pkg::PH_RUN_VAL: begin
				ph = rsd_pkg::PH_OPCODE;
				// zero-length run swallows its value byte silently
				if (remaining != 0) begin
					len       = 32'(remaining);
					remaining = '0;
					issue_write(rsd_pkg::KIND_FILL, len, b);
				end
			end
			rsd_pkg::PH_DUMP: begin
				if (remaining != 0)
					remaining = remaining - 15'd1;
				if (remaining == 0)
					ph = rsd_pkg::PH_OPCODE;
				issue_write(rsd_pkg::KIND_PIXEL, 1, b);
			end
			rsd_pkg::PH_LONG_LO: begin
				long_lo = b;
				ph      = rsd_pkg::PH_LONG_HI;
			end
			rsd_pkg::PH_LONG_HI: begin
				code = {b, long_lo};
				ph   = rsd_pkg::PH_OPCODE;
				if (code == rsd_pkg::LONG_STOP) begin
					stopped         = 1'b1;
					c.command_kind  = rsd_pkg::KIND_STOP;
					c.pixel_address = wr_addr[15:0];
					c.run_length    = '0;
					c.pixel_value   = '0;
					expected_cmds.push_back(c);
				end else if (code >= rsd_pkg::LONG_RUN_BASE) begin
					remaining = 15'(code - rsd_pkg::LONG_RUN_BASE);
					ph        = rsd_pkg::PH_RUN_VAL;
				end else if (code < rsd_pkg::LONG_DMP_BASE) begin
					advance_addr(32'(code));
				end else begin
					// a long dump of zero bytes goes straight back to opcode
					remaining = 15'(code - rsd_pkg::LONG_DMP_BASE);
					if (remaining != 0)
						ph = rsd_pkg::PH_DUMP;
				end
			end
			default: ph = rsd_pkg::PH_OPCODE;
		endcase
	endtask

	// ------------------------------------------------------------------
	// Item driver: called and returns on a falling edge
	// ------------------------------------------------------------------
	task automatic send_item(input logic [7:0] b, input bit start);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			code_ch.valid <= 1'b0;
			@(negedge clk);
		end
		code_ch.valid        <= 1'b1;
		code_ch.code_byte    <= b;
		code_ch.record_start <= start;
		@(posedge clk);
		while (!code_ch.ready)
			@(posedge clk);
		decode_byte(b, start);
		items_sent++;
		@(negedge clk);
	endtask

	// Record bytes: the first one after start_pending carries record_start.
	task automatic send_code(input logic [7:0] b);
		send_item(b, start_pending);
		start_pending = 1'b0;
	endtask

	task automatic send_long(input logic [15:0] code);
		send_code(rsd_pkg::OPC_LONG);
		send_code(code[7:0]);
		send_code(code[15:8]);
	endtask

	task automatic send_record(input logic [7:0] bytes[$]);
		start_pending = 1'b1;
		foreach (bytes[i])
			send_code(bytes[i]);
	endtask

	// Drop valid and let the decoder drain. Bytes that produce no command
	// can still be in flight when the queue empties, hence the extra cycles.
	task automatic wait_drained();
		code_ch.valid <= 1'b0;
		while (expected_cmds.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic set_frame_pixels(input logic [15:0] px);
		wait_drained();
		cfg_we    <= 1'b1;
		cfg_wdata <= px;
		@(negedge clk);
		cfg_we   <= 1'b0;
		frame_px = px;
	endtask

	function automatic logic [15:0] pick_frame_size();
		case ($urandom_range(0, 4))
			0:       return 16'd1;
			1:       return 16'hFFFF;
			2:       return rsd_pkg::FRAME_PIXELS_RESET;
			3:       return 16'($urandom_range(1, 600));
			default: return 16'($urandom_range(1, 65535));
		endcase
	endfunction

	// One record of random operations, mostly well formed; a few carry
	// stray bytes or stray record starts, or are cut off with no stop code.
	task automatic send_random_record();
		int unsigned n;
		int unsigned pick;
		int          n_ops;
		bit          broken;
		start_pending = 1'b1;
		broken        = 1'b0;
		n_ops         = $urandom_range(1, 10);
		for (int i = 0; i < n_ops && !broken; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 6) begin
				send_item(8'($urandom_range(0, 255)),
					start_pending || ($urandom_range(0, 15) == 0));
				start_pending = 1'b0;
			end else if (pick < 30) begin
				// short dump
				n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 127)
					: $urandom_range(1, 6);
				send_code(8'(n));
				repeat (n) send_code(8'($urandom_range(0, 255)));
			end else if (pick < 46) begin
				// short run, sometimes of length zero
				n = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 255);
				send_code(rsd_pkg::OPC_RUN);
				send_code(8'(n));
				send_code(8'($urandom_range(0, 255)));
			end else if (pick < 56) begin
				send_code(8'($urandom_range(8'h81, 8'hFF)));
			end else if (pick < 64) begin
				n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 16'h7FFF)
					: $urandom_range(1, 300);
				send_long(16'(n));
			end else if (pick < 76) begin
				send_long(16'(rsd_pkg::LONG_RUN_BASE + $urandom_range(0, 16'h3FFF)));
				send_code(8'($urandom_range(0, 255)));
			end else if (pick < 90) begin
				n = $urandom_range(0, 8);
				send_long(16'(rsd_pkg::LONG_DMP_BASE + n));
				repeat (n) send_code(8'($urandom_range(0, 255)));
			end else begin
				// cut off inside a long code
				send_code(rsd_pkg::OPC_LONG);
				if ($urandom_range(0, 1) != 0)
					send_code(8'($urandom_range(0, 255)));
				broken = 1'b1;
			end
		end
		if (!broken && $urandom_range(0, 9) != 0) begin
			send_long(rsd_pkg::LONG_STOP);
			repeat ($urandom_range(0, 2)) send_code(8'($urandom_range(0, 255)));
		end
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Every opcode but the long skip at the reset frame size, zero-length runs and
	// dumps, and a byte after the stop code that must be ignored.
	task automatic test_opcodes();
		logic [7:0] seq[$];
		seq = '{8'h01, 8'hFF,                 // dump one byte
			8'h00, 8'h03, 8'hAA,              // short run
			8'h00, 8'h00, 8'h55,              // short run, length zero
			8'hFF,                            // short skip 127
			8'h80, 8'h00, 8'h80,              // long dump, length zero
			8'h80, 8'h05, 8'hC0, 8'h12,       // long run of 5
			8'h80, 8'h00, 8'h00,              // stop
			8'h01};                           // ignored
		send_record(seq);
	endtask

	// Largest frame: last pixel fits, the next overflows, then the address
	// saturates and the stop reports its low 16 bits.
	task automatic test_frame_limits();
		logic [7:0] seq[$];
		set_frame_pixels(16'hFFFF);
		seq = '{8'h80, 8'hFF, 8'h7F, 8'h80, 8'hFF, 8'h7F,
			8'h02, 8'h01, 8'h02,
			8'h80, 8'hFF, 8'h7F, 8'h80, 8'hFF, 8'h7F, 8'hFF,
			8'h80, 8'h00, 8'h00};
		send_record(seq);
	endtask

	// Receiver holds off for a long stretch while a short dump keeps coming,
	// so the output buffer fills and the input side must stall.
	task automatic test_backpressure();
		src_idle_pct  = 0;
		snk_stall_pct = 0;
		set_frame_pixels(rsd_pkg::FRAME_PIXELS_RESET);
		hold_off_left = 300;
		start_pending = 1'b1;
		send_code(8'd40);
		repeat (40) send_code(8'($urandom_range(0, 255)));
		send_long(rsd_pkg::LONG_STOP);
	endtask

	task automatic test_random_traffic(input int src_pct, input int snk_pct,
			input logic [15:0] first_px, input int n_items);
		int stop_at;
		int recs;
		src_idle_pct  = src_pct;
		snk_stall_pct = snk_pct;
		stop_at       = items_sent + n_items;
		recs          = 0;
		while (items_sent < stop_at) begin
			// frame size changes every eight records, only while drained
			if (recs % 8 == 0)
				set_frame_pixels((recs == 0) ? first_px : pick_frame_size());
			send_random_record();
			recs++;
		end
	endtask

	// ------------------------------------------------------------------
	// Receiver: ready changes on the falling edge
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (hold_off_left > 0) begin
			cmd_ch.ready <= 1'b0;
			hold_off_left--;
		end else begin
			cmd_ch.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
		end
	end

	// ------------------------------------------------------------------
	// Result checker: every accepted command against the oldest expectation
	// ------------------------------------------------------------------
	rsd_pkg::cmd_t got_cmd;
	rsd_pkg::cmd_t want_cmd;

	task automatic flag_mismatch(input string what, input rsd_pkg::cmd_t want,
			input rsd_pkg::cmd_t got);
		mismatch_count++;
		if (mismatch_count <= 10) begin
			$display("%0t %s: expected kind %0d addr %0d len %0d value %02h",
				$realtime, what, want.command_kind, want.pixel_address,
				want.run_length, want.pixel_value);
			$display("    got kind %0d addr %0d len %0d value %02h",
				got.command_kind, got.pixel_address, got.run_length,
				got.pixel_value);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && cmd_ch.valid && cmd_ch.ready) begin
			got_cmd.command_kind  = cmd_ch.command_kind;
			got_cmd.pixel_address = cmd_ch.pixel_address;
			got_cmd.run_length    = cmd_ch.run_length;
			got_cmd.pixel_value   = cmd_ch.pixel_value;
			if (expected_cmds.size() == 0) begin
				flag_mismatch("unexpected command", '0, got_cmd);
			end else begin
				want_cmd = expected_cmds.pop_front();
				if (got_cmd.command_kind !== want_cmd.command_kind
						|| got_cmd.pixel_address !== want_cmd.pixel_address
						|| got_cmd.run_length !== want_cmd.run_length
						|| got_cmd.pixel_value !== want_cmd.pixel_value)
					flag_mismatch("command mismatch", want_cmd, got_cmd);
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("end of test: mismatches");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n               = 1'b0;
		cfg_we               = 1'b0;
		cfg_wdata            = '0;
		code_ch.valid        = 1'b0;
		code_ch.code_byte    = '0;
		code_ch.record_start = 1'b0;
		frame_px             = rsd_pkg::FRAME_PIXELS_RESET;
		decode_byte(8'h00, 1'b1);
		expected_cmds.delete();
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_opcodes();
		test_frame_limits();
		test_backpressure();
		test_random_traffic(0, 0, 16'd1, 400);
		test_random_traffic(64, 0, rsd_pkg::FRAME_PIXELS_RESET, 400);
		test_random_traffic(0, 64, 16'hFFFF, 400);
		test_random_traffic(6, 6, 16'd777, 400);

		wait_drained();
		repeat (10) @(negedge clk);
		if (mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
